[rtl/lsd_pkg.sv]
`default_nettype none
package lsd_pkg;

    // Width of the Bernoulli range operands that are actually used.
    localparam int RANGE_BITS = 16;

    localparam int OP_W      = 2;
    localparam int VALUE_W   = 64;
    localparam int FIELD_W   = 16;
    localparam int SAMPLE_W  = 32;
    localparam int HALF_W    = VALUE_W / 2;
    localparam int S_TDATA_W = VALUE_W + 2 * FIELD_W;
    localparam int M_RAW_W   = SAMPLE_W + VALUE_W + 1;
    localparam int M_TDATA_W = ((M_RAW_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_RAW_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int REM_CNT_W = $clog2(SAMPLE_W + 1);

    localparam logic [VALUE_W-1:0] LCG_MUL    = 64'hbf58476d1ce4e5b9;
    localparam logic [VALUE_W-1:0] LCG_ADD    = 64'h94d049bb133111eb;
    localparam logic [VALUE_W-1:0] MIX_GOLDEN = 64'h9e3779b97f4a7c15;
    localparam logic [VALUE_W-1:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
    localparam logic [VALUE_W-1:0] MIX_MUL_B  = 64'h94d049bb133111eb;
    localparam int MIX_SHIFT_1 = 30;
    localparam int MIX_SHIFT_2 = 27;
    localparam int MIX_SHIFT_3 = 31;

    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_DRAW = 2'd1;
    localparam logic [OP_W-1:0] OP_MIX  = 2'd2;

    typedef enum logic [1:0] {
        KIND_NOP,
        KIND_LOAD,
        KIND_DRAW,
        KIND_MIX
    } kind_t;

    typedef struct packed {
        kind_t                 kind;
        logic [VALUE_W-1:0]    value;
        logic [RANGE_BITS-1:0] num;
        logic [RANGE_BITS-1:0] den;
        logic                  den_zero;
    } cmd_t;

    typedef enum logic [2:0] {
        MUL_IDLE,
        MUL_LO,
        MUL_CROSS_A,
        MUL_CROSS_B,
        MUL_SUM,
        MUL_DONE
    } mul_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_LCG_MUL,
        B_MIX_ADD,
        B_MIX_MUL1,
        B_MIX_MUL2,
        B_REM,
        B_OUT
    } back_state_t;

endpackage
`default_nettype wire

[rtl/lsd_front.sv]
`default_nettype none
module lsd_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [lsd_pkg::OP_W-1:0]      in_op,
    input  wire logic [lsd_pkg::S_TDATA_W-1:0] in_data,
    output logic                               cmd_valid,
    input  wire logic                          cmd_ready,
    output lsd_pkg::cmd_t                      cmd
);
    import lsd_pkg::*;

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic [FIELD_W-1:0] num_field;
    logic [FIELD_W-1:0] den_field;

    assign in_ready  = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;
    assign num_field = in_data[VALUE_W +: FIELD_W];
    assign den_field = in_data[VALUE_W + FIELD_W +: FIELD_W];

    always_comb
    begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        if (cmd_ready)
        begin
            valid_next = 1'b0;
        end
        if (in_valid && in_ready)
        begin
            valid_next     = 1'b1;
            cmd_next.value = in_data[VALUE_W-1:0];
            cmd_next.num   = RANGE_BITS'(num_field);
            cmd_next.den   = RANGE_BITS'(den_field);
            cmd_next.den_zero = (RANGE_BITS'(den_field) == '0);
            case (in_op)
                OP_LOAD: cmd_next.kind = KIND_LOAD;
                OP_DRAW: cmd_next.kind = KIND_DRAW;
                OP_MIX:  cmd_next.kind = KIND_MIX;
                default: cmd_next.kind = KIND_NOP;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule
`default_nettype wire

[rtl/lsd_queue.sv]
`default_nettype none
module lsd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_valid,
    output logic               wr_ready,
    input  wire lsd_pkg::cmd_t wr_cmd,
    output logic               rd_valid,
    input  wire logic          rd_ready,
    output lsd_pkg::cmd_t      rd_cmd
);
    import lsd_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;

    assign wr_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule
`default_nettype wire

[rtl/lsd_mul64.sv]
`default_nettype none
// Low 64 bits of a 64 x 64 product, built from three 32 x 32 partial products,
// one per cycle. The high x high product never reaches the low half.
module lsd_mul64 (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [lsd_pkg::VALUE_W-1:0] a,
    input  wire logic [lsd_pkg::VALUE_W-1:0] b,
    output logic                             done,
    output logic [lsd_pkg::VALUE_W-1:0]      p
);
    import lsd_pkg::*;

    mul_state_t         state_reg;
    mul_state_t         state_next;
    logic [VALUE_W-1:0] a_reg;
    logic [VALUE_W-1:0] a_next;
    logic [VALUE_W-1:0] b_reg;
    logic [VALUE_W-1:0] b_next;
    logic [VALUE_W-1:0] prod_reg;
    logic [VALUE_W-1:0] prod_next;
    logic [VALUE_W-1:0] acc_reg;
    logic [VALUE_W-1:0] acc_next;
    logic [HALF_W-1:0]  mul_x;
    logic [HALF_W-1:0]  mul_y;

    assign done = (state_reg == MUL_DONE);
    assign p    = acc_reg;

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        mul_x      = a_reg[HALF_W-1:0];
        mul_y      = b_reg[HALF_W-1:0];
        case (state_reg)
            MUL_CROSS_A:
            begin
                mul_x = a_reg[VALUE_W-1:HALF_W];
            end
            MUL_CROSS_B:
            begin
                mul_y = b_reg[VALUE_W-1:HALF_W];
            end
            default:
            begin
            end
        endcase
        prod_next = VALUE_W'(mul_x) * VALUE_W'(mul_y);
        case (state_reg)
            MUL_IDLE, MUL_DONE:
            begin
                state_next = MUL_IDLE;
                prod_next  = prod_reg;
            end
            MUL_LO:
            begin
                state_next = MUL_CROSS_A;
            end
            MUL_CROSS_A:
            begin
                acc_next   = prod_reg;
                state_next = MUL_CROSS_B;
            end
            MUL_CROSS_B:
            begin
                acc_next[VALUE_W-1:HALF_W] = acc_reg[VALUE_W-1:HALF_W] + prod_reg[HALF_W-1:0];
                state_next = MUL_SUM;
            end
            MUL_SUM:
            begin
                acc_next[VALUE_W-1:HALF_W] = acc_reg[VALUE_W-1:HALF_W] + prod_reg[HALF_W-1:0];
                prod_next  = prod_reg;
                state_next = MUL_DONE;
            end
            default:
            begin
                state_next = MUL_IDLE;
            end
        endcase
        if (start)
        begin
            a_next     = a;
            b_next     = b;
            state_next = MUL_LO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MUL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

endmodule
`default_nettype wire

[rtl/lsd_rem.sv]
`default_nettype none
// Restoring remainder, one dividend bit per cycle, most significant first.
module lsd_rem (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [lsd_pkg::SAMPLE_W-1:0]   dividend,
    input  wire logic [lsd_pkg::RANGE_BITS-1:0] divisor,
    output logic                                done,
    output logic [lsd_pkg::RANGE_BITS-1:0]      rem
);
    import lsd_pkg::*;

    logic                  busy_reg;
    logic                  busy_next;
    logic [REM_CNT_W-1:0]  cnt_reg;
    logic [REM_CNT_W-1:0]  cnt_next;
    logic [SAMPLE_W-1:0]   quo_reg;
    logic [SAMPLE_W-1:0]   quo_next;
    logic [RANGE_BITS-1:0] den_reg;
    logic [RANGE_BITS-1:0] den_next;
    logic [RANGE_BITS-1:0] rem_reg;
    logic [RANGE_BITS-1:0] rem_next;
    logic [RANGE_BITS:0]   trial;
    logic [RANGE_BITS:0]   diff;

    assign done  = busy_reg && (cnt_reg == '0);
    assign rem   = rem_reg;
    assign trial = {rem_reg, quo_reg[SAMPLE_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
                quo_next = {quo_reg[SAMPLE_W-2:0], 1'b0};
                // The partial remainder stays below the divisor, so the
                // trial value is under twice the divisor.
                rem_next = (trial >= {1'b0, den_reg}) ? diff[RANGE_BITS-1:0]
                                                      : trial[RANGE_BITS-1:0];
            end
        end
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = REM_CNT_W'(SAMPLE_W);
            quo_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

endmodule
`default_nettype wire

[rtl/lsd_back.sv]
`default_nettype none
module lsd_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    output logic                               cmd_ready,
    input  wire lsd_pkg::cmd_t                 cmd,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [lsd_pkg::M_TDATA_W-1:0]      out_data,
    output logic                               out_bad
);
    import lsd_pkg::*;

    back_state_t           state_reg;
    back_state_t           state_next;
    cmd_t                  cmd_reg;
    cmd_t                  cmd_next;
    logic [VALUE_W-1:0]    gen_state_reg;
    logic [VALUE_W-1:0]    gen_state_next;
    logic [VALUE_W-1:0]    work_reg;
    logic [VALUE_W-1:0]    work_next;
    logic [SAMPLE_W-1:0]   sample_reg;
    logic [SAMPLE_W-1:0]   sample_next;
    logic [VALUE_W-1:0]    mixed_reg;
    logic [VALUE_W-1:0]    mixed_next;
    logic                  hit_reg;
    logic                  hit_next;
    logic                  bad_reg;
    logic                  bad_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [M_TDATA_W-1:0]  out_data_reg;
    logic [M_TDATA_W-1:0]  out_data_next;
    logic                  out_bad_reg;
    logic                  out_bad_next;
    logic                  out_load;
    logic                  mul_start;
    logic [VALUE_W-1:0]    mul_a;
    logic [VALUE_W-1:0]    mul_b;
    logic                  mul_done;
    logic [VALUE_W-1:0]    mul_p;
    logic                  rem_start;
    logic                  rem_done;
    logic [RANGE_BITS-1:0] rem_val;
    logic [VALUE_W-1:0]    mix_v;
    logic [VALUE_W-1:0]    fin;
    // Marks that the divider has been started for the current draw.
    logic                  rem_pending_reg;
    logic                  rem_pending_next;

    lsd_mul64 u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    lsd_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (sample_reg),
        .divisor  (cmd_reg.den),
        .done     (rem_done),
        .rem      (rem_val)
    );

    assign cmd_ready = (state_reg == B_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_bad   = out_bad_reg;
    assign out_load  = (state_reg == B_OUT) && (!out_valid_reg || out_ready);
    assign mix_v     = work_reg + MIX_GOLDEN;
    assign fin       = mul_p ^ (mul_p >> MIX_SHIFT_3);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        gen_state_next = gen_state_reg;
        work_next      = work_reg;
        sample_next    = sample_reg;
        mixed_next     = mixed_reg;
        hit_next       = hit_reg;
        bad_next       = bad_reg;
        mul_start      = 1'b0;
        mul_a          = gen_state_reg;
        mul_b          = LCG_MUL;
        rem_start      = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next    = cmd;
                    work_next   = cmd.value;
                    sample_next = '0;
                    mixed_next  = '0;
                    hit_next    = 1'b0;
                    bad_next    = 1'b0;
                    case (cmd.kind)
                        KIND_LOAD:
                        begin
                            gen_state_next = cmd.value;
                            state_next     = B_OUT;
                        end
                        KIND_DRAW:
                        begin
                            mul_start  = 1'b1;
                            state_next = B_LCG_MUL;
                        end
                        KIND_MIX:
                        begin
                            state_next = B_MIX_ADD;
                        end
                        default:
                        begin
                            state_next = B_OUT;
                        end
                    endcase
                end
            end
            B_LCG_MUL:
            begin
                if (mul_done)
                begin
                    gen_state_next = mul_p + LCG_ADD;
                    work_next      = mul_p + LCG_ADD;
                    state_next     = B_MIX_ADD;
                end
            end
            B_MIX_ADD:
            begin
                mul_start  = 1'b1;
                mul_a      = mix_v ^ (mix_v >> MIX_SHIFT_1);
                mul_b      = MIX_MUL_A;
                state_next = B_MIX_MUL1;
            end
            B_MIX_MUL1:
            begin
                mul_a = mul_p ^ (mul_p >> MIX_SHIFT_2);
                mul_b = MIX_MUL_B;
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    state_next = B_MIX_MUL2;
                end
            end
            B_MIX_MUL2:
            begin
                if (mul_done)
                begin
                    if (cmd_reg.kind == KIND_DRAW)
                    begin
                        sample_next = fin[VALUE_W-1:VALUE_W-SAMPLE_W];
                        if (cmd_reg.den_zero)
                        begin
                            bad_next   = 1'b1;
                            state_next = B_OUT;
                        end
                        else
                        begin
                            state_next = B_REM;
                        end
                    end
                    else
                    begin
                        mixed_next = fin;
                        state_next = B_OUT;
                    end
                end
            end
            B_REM:
            begin
                // The sample register is loaded in the cycle before the divider starts.
                if (rem_done)
                begin
                    hit_next   = (rem_val < cmd_reg.num);
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (out_load)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
        if ((state_reg == B_MIX_MUL2) && mul_done && (cmd_reg.kind == KIND_DRAW)
            && !cmd_reg.den_zero)
        begin
            rem_start = 1'b0;
        end
        if (state_reg == B_REM)
        begin
            rem_start = !rem_pending_reg;
        end
    end

    always_comb
    begin
        rem_pending_next = rem_pending_reg;
        if (state_reg != B_REM)
        begin
            rem_pending_next = 1'b0;
        end
        else if (rem_start)
        begin
            rem_pending_next = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_bad_next   = out_bad_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {{M_PAD_W{1'b0}}, hit_reg, mixed_reg, sample_reg};
            out_bad_next   = bad_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= B_IDLE;
            gen_state_reg   <= '0;
            out_valid_reg   <= 1'b0;
            rem_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            gen_state_reg   <= gen_state_next;
            out_valid_reg   <= out_valid_next;
            rem_pending_reg <= rem_pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        work_reg     <= work_next;
        sample_reg   <= sample_next;
        mixed_reg    <= mixed_next;
        hit_reg      <= hit_next;
        bad_reg      <= bad_next;
        out_data_reg <= out_data_next;
        out_bad_reg  <= out_bad_next;
    end

endmodule
`default_nettype wire

[rtl/lcg_splitmix_random_draw_unit.sv]
// Items are carried out one at a time: the back end takes no new item before the last one
// is through. The pace is set by the shared 64-bit multiplier and the bit-serial remainder
// unit, which a draw with a zero denominator skips.
// Reset (rst_n, asynchronous, active low) clears the generator state to zero.
`default_nettype none
module lcg_splitmix_random_draw_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // value, numerator, denominator
    input  wire logic [lsd_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // operation
    input  wire logic [lsd_pkg::OP_W-1:0]      s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // sample, mixed, hit, zero padding
    output logic [lsd_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // bad_denominator
    output logic                               m_axis_tuser
);
    import lsd_pkg::*;

    logic front_valid;
    logic front_ready;
    cmd_t front_cmd;
    logic back_valid;
    logic back_ready;
    cmd_t back_cmd;

    lsd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (s_axis_tuser),
        .in_data   (s_axis_tdata),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    lsd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_cmd   (front_cmd),
        .rd_valid (back_valid),
        .rd_ready (back_ready),
        .rd_cmd   (back_cmd)
    );

    lsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .cmd       (back_cmd),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_bad   (m_axis_tuser)
    );

endmodule
`default_nettype wire

[rtl/lsd_checker.sv]
`default_nettype none
module lsd_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    input  wire logic                          s_axis_tready,
    input  wire logic [lsd_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  wire logic [lsd_pkg::OP_W-1:0]      s_axis_tuser,
    input  wire logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic [lsd_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  wire logic                          m_axis_tuser
);
    import lsd_pkg::*;

    // A stalled result must hold.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // A result never carries both a sample and a mixed value.
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[SAMPLE_W-1:0] == '0)
            || (m_axis_tdata[SAMPLE_W +: VALUE_W] == '0))
        else $error("sample and mixed both nonzero");

    // A flagged draw reports no hit.
    a_bad_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[SAMPLE_W + VALUE_W])
        else $error("hit with zero denominator");

    // A flagged result is a draw, so its mixed field is zero.
    a_bad_is_draw: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[SAMPLE_W +: VALUE_W] == '0))
        else $error("flag on a mix result");

endmodule

bind lcg_splitmix_random_draw_unit lsd_checker u_lsd_checker (.*);
`default_nettype wire
